>>> rtl/tpd_pkg.sv
package tpd_pkg;

  // Packet framing
  localparam int unsigned PosW   = 14;
  localparam int unsigned PartW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BtnW   = 6;

  localparam logic [BtnW-1:0] ButtonIdReset = 6'd1;

  // Packet queue between framer and emitter
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Result kinds
  typedef enum logic {
    KIND_MOTION = 1'b0,
    KIND_BUTTON = 1'b1
  } event_kind_t;

  // Framer states, one per byte slot of a packet
  typedef enum logic [4:0] {
    ST_HUNT = 5'b00001,
    ST_XH   = 5'b00010,
    ST_XL   = 5'b00100,
    ST_YH   = 5'b01000,
    ST_YL   = 5'b10000
  } frame_state_t;

  // One complete packet as handed from the framer to the emitter
  typedef struct packed {
    logic            touch;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } packet_t;

endpackage

>>> rtl/tpd_framer.sv
module tpd_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  input  logic [tpd_pkg::ByteW-1:0]    rx_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output tpd_pkg::packet_t             q_push_data
);

  tpd_pkg::frame_state_t state, state_next;
  logic                        packet_touch;
  logic [tpd_pkg::PartW-1:0]   x_high_part;
  logic [tpd_pkg::PartW-1:0]   x_low_part;
  logic [tpd_pkg::PartW-1:0]   y_high_part;
  logic                        rx_take;

  // Hold the final byte while the queue has no room
  assign rx_stall = (state == tpd_pkg::ST_YL) && q_full;
  assign rx_take  = rx_valid && !rx_stall;

  // Push a finished packet on the last byte
  assign q_push            = rx_take && (state == tpd_pkg::ST_YL);
  assign q_push_data.touch = packet_touch;
  assign q_push_data.x     = {x_high_part, x_low_part};
  assign q_push_data.y     = {y_high_part, rx_byte[tpd_pkg::PartW-1:0]};

  // Advance through the byte slots of a packet
  always_comb begin
    state_next = state;
    if (rx_take) begin
      unique case (state)
        tpd_pkg::ST_HUNT: begin
          if (rx_byte[tpd_pkg::ByteW-1]) state_next = tpd_pkg::ST_XH;
        end
        tpd_pkg::ST_XH: state_next = tpd_pkg::ST_XL;
        tpd_pkg::ST_XL: state_next = tpd_pkg::ST_YH;
        tpd_pkg::ST_YH: state_next = tpd_pkg::ST_YL;
        tpd_pkg::ST_YL: state_next = tpd_pkg::ST_HUNT;
        default:        state_next = tpd_pkg::ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpd_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // Capture packet parts as they arrive
  always_ff @(posedge clk) begin
    if (rx_take) begin
      unique case (state)
        tpd_pkg::ST_HUNT: packet_touch <= rx_byte[0];
        tpd_pkg::ST_XH:   x_high_part  <= rx_byte[tpd_pkg::PartW-1:0];
        tpd_pkg::ST_XL:   x_low_part   <= rx_byte[tpd_pkg::PartW-1:0];
        tpd_pkg::ST_YH:   y_high_part  <= rx_byte[tpd_pkg::PartW-1:0];
        tpd_pkg::ST_YL: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_push_only_last: assert property (@(posedge clk) disable iff (rst)
    q_push |-> $past(state_next) == tpd_pkg::ST_YL || state == tpd_pkg::ST_YL)
    else $error("packet pushed outside last byte slot");

  a_stall_only_last: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> state == tpd_pkg::ST_YL && q_full)
    else $error("framer stalled outside last byte slot");

  a_header_starts: assert property (@(posedge clk) disable iff (rst)
    (rx_take && state == tpd_pkg::ST_HUNT && !rx_byte[tpd_pkg::ByteW-1])
      |=> state == tpd_pkg::ST_HUNT)
    else $error("framer left hunting on a data byte");

endmodule

>>> rtl/tpd_queue.sv
module tpd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tpd_pkg::packet_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output tpd_pkg::packet_t pop_data
);

  tpd_pkg::packet_t                entries [tpd_pkg::QueueDepth];
  logic [tpd_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [tpd_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [tpd_pkg::QueueCntW-1:0]   count;
  logic                            do_push;
  logic                            do_pop;

  assign full     = (count == tpd_pkg::QueueCntW'(tpd_pkg::QueueDepth));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming packet
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("packet pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("packet popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tpd_pkg::QueueCntW'(tpd_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

>>> rtl/tpd_emitter.sv
module tpd_emitter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tpd_pkg::BtnW-1:0]     cfg_wdata,
  input  logic                         q_valid,
  input  tpd_pkg::packet_t             q_data,
  output logic                         q_pop,
  output logic                         ev_valid,
  input  logic                         ev_stall,
  output logic                         event_kind,
  output logic [tpd_pkg::PosW-1:0]     pos_x,
  output logic [tpd_pkg::PosW-1:0]     pos_y,
  output logic                         touching,
  output logic [tpd_pkg::BtnW-1:0]     button,
  output logic                         last_of_run
);

  logic [tpd_pkg::BtnW-1:0]  button_id;
  logic [tpd_pkg::PosW-1:0]  held_x;
  logic [tpd_pkg::PosW-1:0]  held_y;
  logic                      reported_down;
  logic                      pend;
  logic [tpd_pkg::PosW-1:0]  pend_x;
  logic [tpd_pkg::PosW-1:0]  pend_y;
  logic                      pend_touch;
  logic                      load_ok;
  logic                      take_btn;
  logic [tpd_pkg::PosW-1:0]  rep_x;
  logic [tpd_pkg::PosW-1:0]  rep_y;
  logic                      change;

  // Output register is free when empty or being transferred
  assign load_ok  = !ev_valid || !ev_stall;
  assign take_btn = load_ok && pend;
  assign q_pop    = load_ok && !pend && q_valid;

  // Touch packets report their own position, releases the held one
  assign rep_x  = q_data.touch ? q_data.x : held_x;
  assign rep_y  = q_data.touch ? q_data.y : held_y;
  assign change = (reported_down != q_data.touch);

  // Control and tracked touch state
  always_ff @(posedge clk) begin
    if (rst) begin
      button_id     <= tpd_pkg::ButtonIdReset;
      held_x        <= '0;
      held_y        <= '0;
      reported_down <= 1'b0;
      pend          <= 1'b0;
      ev_valid      <= 1'b0;
    end else begin
      if (cfg_we) button_id <= cfg_wdata;
      if (load_ok) ev_valid <= take_btn || q_pop;
      if (take_btn) pend <= 1'b0;
      if (q_pop) begin
        pend <= change;
        if (q_data.touch) begin
          held_x <= q_data.x;
          held_y <= q_data.y;
        end
        if (change) reported_down <= q_data.touch;
      end
    end
  end

  // Result payload and the button result waiting behind a motion result
  always_ff @(posedge clk) begin
    if (take_btn) begin
      event_kind  <= tpd_pkg::KIND_BUTTON;
      pos_x       <= pend_x;
      pos_y       <= pend_y;
      touching    <= pend_touch;
      button      <= button_id;
      last_of_run <= 1'b1;
    end else if (q_pop) begin
      event_kind  <= tpd_pkg::KIND_MOTION;
      pos_x       <= rep_x;
      pos_y       <= rep_y;
      touching    <= q_data.touch;
      button      <= '0;
      last_of_run <= !change;
      pend_x      <= rep_x;
      pend_y      <= rep_y;
      pend_touch  <= q_data.touch;
    end
  end

  a_pend_behind_motion: assert property (@(posedge clk) disable iff (rst)
    pend |-> ev_valid && event_kind == tpd_pkg::KIND_MOTION && !last_of_run)
    else $error("button result pending without its motion result");

  a_button_is_last: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_kind == tpd_pkg::KIND_BUTTON |-> last_of_run)
    else $error("button result not marked last");

  a_state_follows_button: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_kind == tpd_pkg::KIND_BUTTON |-> reported_down == touching)
    else $error("reported touch state out of step with button result");

endmodule

>>> rtl/touch_packet_decoder.sv
// Channel   Handshake             Payload
// rx        rx_valid / rx_stall   rx_byte
// ev        ev_valid / ev_stall   event_kind, pos_x, pos_y, touching, button, last_of_run
// cfg       cfg_we                cfg_wdata (button_id)
//
// One byte is taken per cycle while rx_stall is low; a packet's motion result
// passes the queue and the emitter's output register, a button result after it.
// A two-entry packet queue sits between framer and emitter, so rx stalls
// only on a last byte while that queue is full.
// Reset (rst, synchronous) returns the framer to hunting and clears the
// held position, reported touch state and queue; button_id returns to 1.
module touch_packet_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tpd_pkg::BtnW-1:0]     cfg_wdata,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  input  logic [tpd_pkg::ByteW-1:0]    rx_byte,
  output logic                         ev_valid,
  input  logic                         ev_stall,
  output logic                         event_kind,
  output logic [tpd_pkg::PosW-1:0]     pos_x,
  output logic [tpd_pkg::PosW-1:0]     pos_y,
  output logic                         touching,
  output logic [tpd_pkg::BtnW-1:0]     button,
  output logic                         last_of_run
);

  logic             q_full;
  logic             q_push;
  tpd_pkg::packet_t q_push_data;
  logic             q_pop;
  logic             q_valid;
  tpd_pkg::packet_t q_data;

  tpd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  tpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  tpd_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .ev_valid    (ev_valid),
    .ev_stall    (ev_stall),
    .event_kind  (event_kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .touching    (touching),
    .button      (button),
    .last_of_run (last_of_run)
  );

endmodule

>>> tb/sv/touch_event_checker.sv
// Watches the byte and event channels of the touch packet decoder, predicts
// the events each byte transfer causes and compares them in order.
module touch_event_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tpd_pkg::BtnW-1:0]    cfg_wdata,
  input  logic                        rx_valid,
  input  logic                        rx_stall,
  input  logic [tpd_pkg::ByteW-1:0]   rx_byte,
  input  logic                        ev_valid,
  input  logic                        ev_stall,
  input  logic                        event_kind,
  input  logic [tpd_pkg::PosW-1:0]    pos_x,
  input  logic [tpd_pkg::PosW-1:0]    pos_y,
  input  logic                        touching,
  input  logic [tpd_pkg::BtnW-1:0]    button,
  input  logic                        last_of_run,
  output int                          fail_count,
  output int                          pending
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    tpd_pkg::event_kind_t        kind;
    logic [tpd_pkg::PosW-1:0]    x;
    logic [tpd_pkg::PosW-1:0]    y;
    logic                        touch;
    logic [tpd_pkg::BtnW-1:0]    btn;
    logic                        last;
  } touch_event_t;

  touch_event_t expected_events[$];

  // Shadow of the framer and of the reported touch state
  tpd_pkg::frame_state_t       frame_st;
  logic                        pkt_touch;
  logic [tpd_pkg::PartW-1:0]   xh_part, xl_part, yh_part;
  logic [tpd_pkg::PosW-1:0]    held_x, held_y;
  logic                        shown_down;
  logic [tpd_pkg::BtnW-1:0]    btn_id;

  task automatic note_failure(input string msg);
    if (fail_count < ReportLimit) $display("%s", msg);
    fail_count++;
  endtask

  // Advance the framer by one byte; queue the events of a finished packet
  task automatic frame_byte(input logic [tpd_pkg::ByteW-1:0] b);
    logic [tpd_pkg::PartW-1:0] d;
    logic [tpd_pkg::PosW-1:0]  nx, ny;
    touch_event_t              ev;
    d = b[tpd_pkg::PartW-1:0];
    case (frame_st)
      tpd_pkg::ST_XH: begin
        xh_part = d;
        frame_st = tpd_pkg::ST_XL;
      end
      tpd_pkg::ST_XL: begin
        xl_part = d;
        frame_st = tpd_pkg::ST_YH;
      end
      tpd_pkg::ST_YH: begin
        yh_part = d;
        frame_st = tpd_pkg::ST_YL;
      end
      tpd_pkg::ST_YL: begin
        frame_st = tpd_pkg::ST_HUNT;
        nx = {xh_part, xl_part};
        ny = {yh_part, d};
        // a release reports the last touched position
        if (pkt_touch) begin
          held_x = nx;
          held_y = ny;
        end else begin
          nx = held_x;
          ny = held_y;
        end
        ev.kind = tpd_pkg::KIND_MOTION;
        ev.x = nx;
        ev.y = ny;
        ev.touch = pkt_touch;
        ev.btn = '0;
        ev.last = (shown_down == pkt_touch);
        expected_events.push_back(ev);
        if (shown_down != pkt_touch) begin
          shown_down = pkt_touch;
          ev.kind = tpd_pkg::KIND_BUTTON;
          ev.btn = btn_id;
          ev.last = 1'b1;
          expected_events.push_back(ev);
        end
      end
      default: begin
        // hunt: only a byte with the top bit set opens a packet
        if (b[tpd_pkg::ByteW-1]) begin
          pkt_touch = b[0];
          frame_st = tpd_pkg::ST_XH;
        end else begin
          frame_st = tpd_pkg::ST_HUNT;
        end
      end
    endcase
  endtask

  // Compare one event transfer against the oldest expectation
  task automatic check_event();
    touch_event_t exp_ev;
    if (expected_events.size() == 0) begin
      note_failure($sformatf("unexpected event: kind %0d x %0d y %0d touch %0b btn %0d last %0b",
                             event_kind, pos_x, pos_y, touching, button, last_of_run));
    end else begin
      exp_ev = expected_events.pop_front();
      if (exp_ev.kind != tpd_pkg::event_kind_t'(event_kind) || exp_ev.x != pos_x ||
          exp_ev.y != pos_y || exp_ev.touch != touching || exp_ev.btn != button ||
          exp_ev.last != last_of_run) begin
        note_failure($sformatf({"event mismatch: expected kind %0d x %0d y %0d touch %0b",
                                " btn %0d last %0b, got kind %0d x %0d y %0d touch %0b",
                                " btn %0d last %0b"},
                               exp_ev.kind, exp_ev.x, exp_ev.y, exp_ev.touch, exp_ev.btn,
                               exp_ev.last, event_kind, pos_x, pos_y, touching, button,
                               last_of_run));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_st = tpd_pkg::ST_HUNT;
      pkt_touch = 1'b0;
      xh_part = '0;
      xl_part = '0;
      yh_part = '0;
      held_x = '0;
      held_y = '0;
      shown_down = 1'b0;
      btn_id = tpd_pkg::ButtonIdReset;
      expected_events.delete();
    end else begin
      if (ev_valid && !ev_stall) check_event();
      if (cfg_we) btn_id = cfg_wdata;
      if (rx_valid && !rx_stall) frame_byte(rx_byte);
    end
    pending = expected_events.size();
  end

endmodule

>>> tb/sv/tb.sv
// Drives byte traffic and button_id settings into the touch packet decoder,
// stalls the event side on a pattern of its own and gives the verdict.
module tb;

  localparam int CycleLimit   = 400000;
  localparam int PhaseBytes   = 242;
  localparam int SettleCycles = 4;
  localparam int DrainCycles  = 16;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [tpd_pkg::BtnW-1:0]    cfg_wdata = '0;
  logic                        rx_valid = 1'b0;
  logic                        rx_stall;
  logic [tpd_pkg::ByteW-1:0]   rx_byte = '0;
  logic                        ev_valid;
  logic                        ev_stall = 1'b0;
  logic                        event_kind;
  logic [tpd_pkg::PosW-1:0]    pos_x;
  logic [tpd_pkg::PosW-1:0]    pos_y;
  logic                        touching;
  logic [tpd_pkg::BtnW-1:0]    button;
  logic                        last_of_run;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;
  logic run_stalled = 1'b0;
  logic last_touch = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  touch_packet_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .ev_valid    (ev_valid),
    .ev_stall    (ev_stall),
    .event_kind  (event_kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .touching    (touching),
    .button      (button),
    .last_of_run (last_of_run)
  );

  touch_event_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .ev_valid    (ev_valid),
    .ev_stall    (ev_stall),
    .event_kind  (event_kind),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .touching    (touching),
    .button      (button),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Stall the event side: free, random, or long runs, switching now and then
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 256);
    end
    mode_left--;
    case (stall_mode)
      0: ev_stall <= 1'b0;
      1: ev_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        run_left--;
        ev_stall <= run_stalled;
      end
    endcase
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Send one byte; open a new burst, mostly after a random gap, when the last one ran out
  task automatic push_byte(input logic [tpd_pkg::ByteW-1:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        rx_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 20);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold off the byte side until every expected event has been seen
  task automatic drain_events(input int extra);
    rx_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_button_id(input logic [tpd_pkg::BtnW-1:0] id);
    drain_events(SettleCycles);
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [tpd_pkg::ByteW-1:0] data_byte();
    logic [tpd_pkg::ByteW-1:0] d;
    d = 8'($urandom_range(0, 255));
    // mostly clean data bytes, now and then one with the top bit set
    if ($urandom_range(0, 7) != 0) d[tpd_pkg::ByteW-1] = 1'b0;
    return d;
  endfunction

  // Random traffic: mostly whole packets, some line noise and cut packets
  task automatic send_traffic(input int n_bytes);
    int sent;
    int pick;
    logic [tpd_pkg::ByteW-1:0] hdr;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) begin
          push_byte({1'b0, 7'($urandom_range(0, 127))});
          sent++;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) last_touch = !last_touch;
        hdr = {1'b1, 6'($urandom_range(0, 63)), last_touch};
        push_byte(hdr);
        sent++;
        if (pick < 13) begin
          repeat ($urandom_range(0, 3)) begin
            push_byte(data_byte());
            sent++;
          end
        end else begin
          repeat (4) push_byte(data_byte());
          sent += 4;
        end
      end
    end
  endtask

  // Noise while hunting, extreme coordinates, touch without change,
  // header bits 6..1 set, top bit set in data bytes, release of a held position
  logic [tpd_pkg::ByteW-1:0] directed_bytes[27] = '{
    8'h00, 8'h7F,
    8'h81, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
    8'h83, 8'h01, 8'h02, 8'h03, 8'h04,
    8'h80, 8'h80, 8'hFF, 8'h80, 8'hFF,
    8'hFF, 8'h80, 8'h80, 8'h80, 8'h80,
    8'hFE, 8'h55, 8'h2A, 8'h55, 8'h2A
  };

  logic [tpd_pkg::BtnW-1:0] id_settings[6];

  initial begin
    id_settings = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd2, 6'd0};
    id_settings[4] = 6'($urandom_range(1, 32));
    id_settings[5] = 6'($urandom_range(0, 63));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);

    foreach (id_settings[i]) begin
      write_button_id(id_settings[i]);
      send_traffic(PhaseBytes);
    end

    drain_events(DrainCycles);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tpd_pkg.sv
rtl/tpd_framer.sv
rtl/tpd_queue.sv
rtl/tpd_emitter.sv
rtl/touch_packet_decoder.sv
tb/sv/touch_event_checker.sv
tb/sv/tb.sv
